FILE: hw/rtl/csf_pkg.sv
package csf_pkg;

   // Context store geometry. The context index is the chunk stream id modulo CONTEXTS,
   // and CONTEXTS is a power of two.
   localparam int CONTEXTS = 64;
   localparam int CTX_W    = $clog2(CONTEXTS);

   // Chunk size register.
   localparam int                CHUNK_W     = 17;
   localparam int                MAX_CHUNK   = 65536;
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(128);
   localparam logic [CHUNK_W-1:0] CHUNK_MAX   = CHUNK_W'(MAX_CHUNK);

   // Field widths.
   localparam int CSID_W = 17;
   localparam int TS_W   = 24;
   localparam int LEN_W  = 24;
   localparam int TYPE_W = 8;
   localparam int SID_W  = 32;
   localparam int BYTE_W = 8;

   // Request tdata width: all fields, padded to whole bytes.
   localparam int REQ_FIELDS_W = CSID_W + TS_W + LEN_W + TYPE_W + SID_W + BYTE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_PAYLOAD = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_DATA,
      JOB_DROP
   } job_kind_type;

   typedef struct packed {
      logic [CSID_W-1:0] csid;
      logic [TS_W-1:0]   ts;
      logic [LEN_W-1:0]  len;
      logic [TYPE_W-1:0] mtype;
      logic [SID_W-1:0]  sid;
      logic [BYTE_W-1:0] pbyte;
   } item_type;

   typedef struct packed {
      logic [TS_W-1:0]   ts;
      logic [LEN_W-1:0]  len;
      logic [TYPE_W-1:0] mtype;
      logic [SID_W-1:0]  sid;
   } ctx_type;

   // One unit of work for the back: a header, a payload word or a dropped word.
   typedef struct packed {
      job_kind_type      kind;
      logic [1:0]        fmt;
      logic              cont;
      logic [CSID_W-1:0] csid;
      logic [TS_W-1:0]   tsv;
      logic [LEN_W-1:0]  len;
      logic [TYPE_W-1:0] mtype;
      logic [SID_W-1:0]  sid;
      logic [BYTE_W-1:0] pbyte;
   } job_type;

endpackage

FILE: hw/rtl/chunk_stream_framer_core.sv
// Chunk stream framer.
// The req channel carries message starts and payload words. tuser selects the kind:
// 0 starts a message with the header fields in tdata, 1 carries one payload byte.
// The rsp channel carries the chunked byte stream, one byte per word; tlast marks
// the final word caused by one request, tuser flags a payload word dropped because
// no message was open (its data is zero).
// A start produces 1 to 14 words (basic header plus message header); a payload word
// produces one word, or up to four when a continuation header opens a new chunk.
// The rsp side emits one word per cycle while the receiver takes them, so the request
// rate is set by the number of words each request expands into; plain payload runs at
// one word per cycle. The first response word passes through the lookup register with
// the context store read, the job queue, and the output register.
// The chunk size is written through csr_we/csr_wdata. Write it only while the block is
// idle; the block itself does not enforce this.
// Reset clears the contexts, the open message and the queue, and sets chunk size
// to 128. When the receiver stalls, the output register holds, the 4-entry job
// queue fills, and then req_tready drops.
module chunk_stream_framer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: chunk_stream_id, timestamp, message_length, message_type, stream_id,
   // payload_byte, zero padding
   input  logic [csf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: opcode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: out_byte
   output logic [7:0]                         rsp_tdata,
   output logic                               rsp_tlast,
   // tuser: no_message
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [csf_pkg::CHUNK_W-1:0]        csr_wdata
);
   import csf_pkg::*;

   item_type item;
   op_type   op;
   logic     fq_valid, fq_ready;
   job_type  fq_job;
   logic     qb_valid, qb_ready;
   job_type  qb_job;

   // Unpack the request word.
   assign item = '{csid:  req_tdata[16:0],
                   ts:    req_tdata[40:17],
                   len:   req_tdata[64:41],
                   mtype: req_tdata[72:65],
                   sid:   req_tdata[104:73],
                   pbyte: req_tdata[112:105]};
   assign op   = op_type'(req_tuser);

   csf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (op),
      .req_item  (item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job       (fq_job)
   );

   csf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   csf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_drop  (rsp_tuser)
   );

endmodule

FILE: hw/rtl/csf_front.sv
module csf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  csf_pkg::op_type               req_op,
   input  csf_pkg::item_type             req_item,
   input  logic                          csr_we,
   input  logic [csf_pkg::CHUNK_W-1:0]   csr_wdata,
   output logic                          job_valid,
   input  logic                          job_ready,
   output csf_pkg::job_type              job
);
   import csf_pkg::*;

   // Context store with a valid bit per entry; invalid entries read as zero.
   ctx_type                 ctx_mem [CONTEXTS];
   logic [CONTEXTS-1:0]     ctx_valid_ff;

   // Lookup stage registers.
   logic                    a_valid_ff;
   op_type                  a_op_ff;
   item_type                a_item_ff;
   ctx_type                 a_prev_ff;

   // Open message state.
   logic                    open_ff, open_in;
   logic [CSID_W-1:0]       stream_ff, stream_in;
   logic [LEN_W-1:0]        left_ff, left_in;
   logic [CHUNK_W-1:0]      fill_ff, fill_in;
   logic [CHUNK_W-1:0]      chunk_ff;

   logic                    a_fire;
   logic                    a_take;
   logic                    a_start;
   logic [CTX_W-1:0]        a_ix;
   logic [CTX_W-1:0]        req_ix;
   ctx_type                 new_ctx;
   logic [TS_W-1:0]         delta;
   logic [1:0]              fmt;
   logic [CHUNK_W-1:0]      eff_chunk;
   logic                    cont;
   logic [LEN_W-1:0]        left_dec;

   assign a_fire    = a_valid_ff && job_ready;
   assign req_ready = !a_valid_ff || job_ready;
   assign a_take    = req_valid && req_ready;
   assign a_start   = (a_op_ff == OP_START);
   assign a_ix      = a_item_ff.csid[CTX_W-1:0];
   assign req_ix    = req_item.csid[CTX_W-1:0];
   assign new_ctx   = '{ts: a_item_ff.ts, len: a_item_ff.len,
                        mtype: a_item_ff.mtype, sid: a_item_ff.sid};

   // Chunk size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= CHUNK_RESET;
      end else if (csr_we) begin
         chunk_ff <= csr_wdata;
      end
   end

   // Lookup stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   // Registered context read, with forwarding from a start being retired this cycle.
   always_ff @(posedge clock) begin
      if (a_take) begin
         a_op_ff   <= req_op;
         a_item_ff <= req_item;
         if (a_fire && a_start && (a_ix == req_ix)) begin
            a_prev_ff <= new_ctx;
         end else if (!ctx_valid_ff[req_ix]) begin
            a_prev_ff <= '0;
         end else begin
            a_prev_ff <= ctx_mem[req_ix];
         end
      end
   end

   // Context write when a message start retires.
   always_ff @(posedge clock) begin
      if (a_fire && a_start) begin
         ctx_mem[a_ix] <= new_ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_valid_ff <= '0;
      end else if (a_fire && a_start) begin
         ctx_valid_ff[a_ix] <= 1'b1;
      end
   end

   // Header format choice against the previous header of this context.
   always_comb begin
      delta = a_item_ff.ts - a_prev_ff.ts;
      if ((a_prev_ff.len == '0) || (a_item_ff.sid != a_prev_ff.sid)) begin
         fmt = 2'd0;
      end else if ((a_item_ff.len != a_prev_ff.len) ||
                   (a_item_ff.mtype != a_prev_ff.mtype)) begin
         fmt = 2'd1;
      end else if (a_item_ff.ts != a_prev_ff.ts) begin
         fmt = 2'd2;
      end else begin
         fmt = 2'd3;
      end
   end

   // Effective chunk size and continuation decision for a payload word.
   always_comb begin
      if (chunk_ff > CHUNK_MAX) begin
         eff_chunk = CHUNK_MAX;
      end else if (chunk_ff == '0) begin
         eff_chunk = CHUNK_W'(1);
      end else begin
         eff_chunk = chunk_ff;
      end
      cont     = (fill_ff >= eff_chunk);
      left_dec = left_ff - LEN_W'(1);
   end

   // Job build and next message state.
   always_comb begin
      job       = '0;
      job.csid  = a_item_ff.csid;
      job.tsv   = (fmt == 2'd0) ? a_item_ff.ts : delta;
      job.len   = a_item_ff.len;
      job.mtype = a_item_ff.mtype;
      job.sid   = a_item_ff.sid;
      job.pbyte = a_item_ff.pbyte;
      job.fmt   = fmt;
      job.kind  = JOB_HEADER;
      open_in   = open_ff;
      stream_in = stream_ff;
      left_in   = left_ff;
      fill_in   = fill_ff;
      if (a_start) begin
         open_in   = (a_item_ff.len != '0);
         stream_in = a_item_ff.csid;
         left_in   = a_item_ff.len;
         fill_in   = '0;
      end else if (!open_ff) begin
         job.kind = JOB_DROP;
      end else begin
         job.kind = JOB_DATA;
         job.csid = stream_ff;
         job.cont = cont;
         fill_in  = cont ? CHUNK_W'(1) : fill_ff + CHUNK_W'(1);
         left_in  = left_dec;
         if (left_dec == '0) begin
            open_in = 1'b0;
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         stream_ff <= '0;
         left_ff   <= '0;
         fill_ff   <= '0;
      end else if (a_fire) begin
         open_ff   <= open_in;
         stream_ff <= stream_in;
         left_ff   <= left_in;
         fill_ff   <= fill_in;
      end
   end

   assign job_valid = a_valid_ff;

endmodule

FILE: hw/rtl/csf_queue.sv
module csf_queue #(
   parameter int DEPTH = csf_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  csf_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output csf_pkg::job_type  pop_job
);
   import csf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, rd_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_job    = slot_ff[rd_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

endmodule

FILE: hw/rtl/csf_back.sv
module csf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  csf_pkg::job_type              job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csf_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last,
   output logic                          rsp_drop
);
   import csf_pkg::*;

   logic [3:0]  step_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        drop_ff;
   logic        emit;
   logic [1:0]  nb;
   logic [3:0]  mh;
   logic [3:0]  total;
   logic [3:0]  j;

   // Length of the basic header for a chunk stream id.
   function automatic logic [1:0] basic_len(input logic [CSID_W-1:0] csid);
      if (csid < CSID_W'(64)) begin
         return 2'd1;
      end else if (csid < CSID_W'(320)) begin
         return 2'd2;
      end else begin
         return 2'd3;
      end
   endfunction

   // Byte k of the basic header.
   function automatic logic [7:0] basic_byte(input logic [1:0] fmt,
                                             input logic [CSID_W-1:0] csid,
                                             input logic [3:0] k);
      logic [CSID_W-1:0] off;
      logic [7:0]        b;
      off = csid - CSID_W'(64);
      b   = '0;
      if (k == 4'd0) begin
         if (csid < CSID_W'(64)) begin
            b = {fmt, csid[5:0]};
         end else if (csid < CSID_W'(320)) begin
            b = {fmt, 6'd0};
         end else begin
            b = {fmt, 6'd1};
         end
      end else if (k == 4'd1) begin
         b = off[7:0];
      end else begin
         b = off[15:8];
      end
      return b;
   endfunction

   // Byte j of the message header: timestamp, length, type, stream id little endian.
   function automatic logic [7:0] msg_byte(input job_type jb, input logic [3:0] jj);
      logic [7:0] b;
      b = '0;
      case (jj)
         4'd0:    b = jb.tsv[23:16];
         4'd1:    b = jb.tsv[15:8];
         4'd2:    b = jb.tsv[7:0];
         4'd3:    b = jb.len[23:16];
         4'd4:    b = jb.len[15:8];
         4'd5:    b = jb.len[7:0];
         4'd6:    b = jb.mtype;
         4'd7:    b = jb.sid[7:0];
         4'd8:    b = jb.sid[15:8];
         4'd9:    b = jb.sid[23:16];
         4'd10:   b = jb.sid[31:24];
         default: b = '0;
      endcase
      return b;
   endfunction

   // Word count and current word of the job at the head of the queue.
   always_comb begin
      nb = basic_len(job.csid);
      unique case (job.fmt)
         2'd0:    mh = 4'd11;
         2'd1:    mh = 4'd7;
         2'd2:    mh = 4'd3;
         default: mh = 4'd0;
      endcase
      j       = step_ff - {2'b00, nb};
      byte_in = '0;
      unique case (job.kind)
         JOB_HEADER: begin
            total = {2'b00, nb} + mh;
            if (step_ff < {2'b00, nb}) begin
               byte_in = basic_byte(job.fmt, job.csid, step_ff);
            end else begin
               byte_in = msg_byte(job, j);
            end
         end
         JOB_DATA: begin
            total = job.cont ? {2'b00, nb} + 4'd1 : 4'd1;
            if (job.cont && (step_ff < {2'b00, nb})) begin
               byte_in = basic_byte(2'd3, job.csid, step_ff);
            end else begin
               byte_in = job.pbyte;
            end
         end
         default: begin
            total = 4'd1;
         end
      endcase
      last_in = (step_ff == total - 4'd1);
   end

   assign emit      = job_valid && (!valid_ff || rsp_ready);
   assign job_ready = emit && last_in;

   // Word counter within the current job.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (emit) begin
         step_ff <= last_in ? 4'd0 : step_ff + 4'd1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         drop_ff <= (job.kind == JOB_DROP);
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;
   assign rsp_drop  = drop_ff;

endmodule

FILE: hw/rtl/csf_checker.sv
module csf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // A stalled response word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // A dropped payload word is a single word of its own.
   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("dropped word not marked last");

   // A dropped payload word carries zero data.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("dropped word carries data");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind chunk_stream_framer_core csf_checker u_csf_checker (.*);
